// ===== rtl/core/cbsot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsot_pkg
// Shared types and constants of the cross-block segment overlap tracker.
// ----------------------------------------------------------------------------
package cbsot_pkg;

    // Owner table geometry
    localparam int SEGMENTS         = 4096;
    localparam int SEG_AW           = $clog2(SEGMENTS);
    localparam int MAX_ACCESS_BYTES = 16;

    // Field widths
    localparam int ADDR_W    = 64;
    localparam int ID_W      = 26;
    localparam int CNT_W     = 32;
    localparam int SEGCNT_W  = 13;
    localparam int SHIFT_W   = 5;
    localparam int GDIM_W    = 11;
    localparam int SIZE_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CLS_W     = 3;

    // Table entry: owner valid on top of owner id
    localparam int ENTRY_W = ID_W + 1;

    // Access modes
    localparam logic [1:0] MODE_OTHER = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_STORE = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Access classes
    localparam logic [CLS_W-1:0] CLS_IGNORED = 3'd0;
    localparam logic [CLS_W-1:0] CLS_OTHER   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_STORE   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LOAD    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CROSS   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_OOR     = 3'd5;
    localparam logic [CLS_W-1:0] CLS_CLEARED = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SHIFT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIM_X    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIM_Y    = 8'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic              is_global;
        logic [9:0]        block_x;
        logic [9:0]        block_y;
        logic [5:0]        block_z;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] access_size;
    } in_word_t;

    typedef struct packed {
        logic [CLS_W-1:0]  access_class;
        logic [ID_W-1:0]   flat_block_id;
        logic [CNT_W-1:0]  store_count;
        logic [CNT_W-1:0]  load_count;
        logic [CNT_W-1:0]  cross_load_count;
        logic [CNT_W-1:0]  out_of_range_count;
        logic [ADDR_W-1:0] observed_min;
        logic [ADDR_W-1:0] observed_max;
    } out_word_t;

    // Statistics update request, one per finished item
    typedef struct packed {
        logic clear;
        logic inc_store;
        logic inc_load;
        logic inc_cross;
        logic inc_oor;
        logic track;
    } stat_cmd_t;

    // Statistics as seen after an update
    typedef struct packed {
        logic [CNT_W-1:0]  stores;
        logic [CNT_W-1:0]  loads;
        logic [CNT_W-1:0]  cross_loads;
        logic [CNT_W-1:0]  out_of_range;
        logic [ADDR_W-1:0] lowest;
        logic [ADDR_W-1:0] highest;
    } stats_t;

endpackage

// ===== rtl/core/cbsot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbsot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/cbsot_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsot_stats
// Saturating access counters and observed address range.
// ----------------------------------------------------------------------------
module cbsot_stats (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cbsot_pkg::stat_cmd_t     cmd,
    input  logic [63:0]              address,
    output cbsot_pkg::stats_t        post
);
    import cbsot_pkg::*;

    stats_t stats_reg;
    stats_t stats_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Values after the current request; equal to the registers when idle
    always_comb begin
        stats_next = stats_reg;
        if (cmd.clear) begin
            stats_next = '0;
        end else begin
            if (cmd.inc_store) stats_next.stores       = sat_inc(stats_reg.stores);
            if (cmd.inc_load)  stats_next.loads        = sat_inc(stats_reg.loads);
            if (cmd.inc_cross) stats_next.cross_loads  = sat_inc(stats_reg.cross_loads);
            if (cmd.inc_oor)   stats_next.out_of_range = sat_inc(stats_reg.out_of_range);
            if (cmd.track) begin
                // zero means unset
                if (stats_reg.lowest == '0 || address < stats_reg.lowest) begin
                    stats_next.lowest = address;
                end
                if (stats_reg.highest == '0 || address > stats_reg.highest) begin
                    stats_next.highest = address;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= '0;
        end else begin
            stats_reg <= stats_next;
        end
    end

    assign post = stats_next;

endmodule

// ===== rtl/core/cross_block_segment_overlap_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_block_segment_overlap_tracker_top
// Tracks which thread block owns each address segment and classifies access words.
// ----------------------------------------------------------------------------
// Sequence: an accepted word goes through CALC and DISP, then straight to FIN for
//   ignored, other-op, out-of-range and clear words, through LOAD for loads (owner
//   table read), or through STORE once per segment spanned for stores (one table
//   write per segment inside the table; a zero-byte store writes nothing).
// FIN registers the result word once the output is free; only then is a new word taken.
// Reset and clear: the owner table is swept one entry a cycle over all 4096
//   entries, with s_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module cross_block_segment_overlap_tracker_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cbsot_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                          cfg_data,
    // access words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cbsot_pkg::in_word_t                  s_data,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cbsot_pkg::out_word_t                 m_data
);
    import cbsot_pkg::*;

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_DISP  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_STORE = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // Configuration
    logic [ADDR_W-1:0]   base_reg;
    logic [SEGCNT_W-1:0] segcnt_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [GDIM_W-1:0]   gdx_reg;
    logic [GDIM_W-1:0]   gdy_reg;

    // Control
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [SEG_AW-1:0]   sweep_cnt_reg;
    logic                out_valid_reg;

    // Item datapath
    in_word_t            item_reg;
    logic [ADDR_W-1:0]   off_reg;
    logic [20:0]         prod_y_reg;
    logic [21:0]         gxy_reg;
    logic [27:0]         prod_z_reg;
    logic [SEG_AW-1:0]   seg_idx_reg;
    logic                in_range_reg;
    logic [ID_W-1:0]     flat_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [ADDR_W-1:0]   p_reg;
    logic [SIZE_W-1:0]   left_reg;
    out_word_t           out_data_reg;

    logic                s_fire;
    logic                fin_fire;
    logic                sweep_last;
    logic [SEGCNT_W-1:0] seg_limit;
    logic [ADDR_W-1:0]   seg_full;
    logic [28:0]         flat_sum;
    logic [SIZE_W-1:0]   size_clamped;
    logic [ADDR_W-1:0]   seg_p;
    logic                p_in_range;
    logic [31:0]         seg_size;
    logic [31:0]         seg_rem;
    logic                store_done;
    logic                cross_hit;
    logic [ENTRY_W-1:0]  rd_entry;
    logic                ram_we;
    logic [SEG_AW-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    stat_cmd_t           stat_cmd;
    stats_t              stats_post;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign fin_fire   = (state_reg == ST_FIN) && (!out_valid_reg || m_ready);
    assign sweep_last = (sweep_cnt_reg == SEG_AW'(SEGMENTS - 1));
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    // Effective segment count, saturated at table depth
    assign seg_limit = (segcnt_reg > SEGCNT_W'(SEGMENTS)) ? SEGCNT_W'(SEGMENTS) : segcnt_reg;

    assign seg_full     = off_reg >> shift_reg;
    assign flat_sum     = 29'(item_reg.block_x) + 29'(prod_y_reg) + 29'(prod_z_reg);
    assign size_clamped = (item_reg.access_size > SIZE_W'(MAX_ACCESS_BYTES)) ?
                          SIZE_W'(MAX_ACCESS_BYTES) : item_reg.access_size;

    // Store walk: one segment per cycle, p_reg is the current byte offset
    assign seg_p      = p_reg >> shift_reg;
    assign p_in_range = (seg_p < ADDR_W'(seg_limit));
    assign seg_size   = 32'(1) << shift_reg;
    assign seg_rem    = seg_size - (p_reg[31:0] & (seg_size - 32'(1)));
    assign store_done = (seg_rem >= 32'(left_reg));

    // Load check against table entry read in dispatch
    assign cross_hit = rd_entry[ENTRY_W-1] && (rd_entry[ID_W-1:0] != flat_reg);

    // Table write port: sweep clears, store claims
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = sweep_cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_SWEEP) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_STORE) begin
            ram_we    = p_in_range && (left_reg != '0);
            ram_waddr = seg_p[SEG_AW-1:0];
            ram_wdata = {1'b1, flat_reg};
        end
    end

    cbsot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SEGMENTS)
    ) u_owner_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (seg_idx_reg),
        .rd_data (rd_entry)
    );

    // Statistics update at result time
    always_comb begin
        stat_cmd           = '0;
        stat_cmd.clear     = fin_fire && (cls_reg == CLS_CLEARED);
        stat_cmd.inc_store = fin_fire && (cls_reg == CLS_STORE);
        stat_cmd.inc_load  = fin_fire && (cls_reg inside {CLS_LOAD, CLS_CROSS});
        stat_cmd.inc_cross = fin_fire && (cls_reg == CLS_CROSS);
        stat_cmd.inc_oor   = fin_fire && (cls_reg == CLS_OOR);
        stat_cmd.track     = fin_fire && (cls_reg inside {[CLS_OTHER:CLS_OOR]});
    end

    cbsot_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stat_cmd),
        .address (item_reg.address),
        .post    (stats_post)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: if (sweep_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_CALC;
            ST_CALC:  state_next = ST_DISP;
            ST_DISP: begin
                if (item_reg.mode == MODE_CLEAR || !item_reg.is_global || !in_range_reg) begin
                    state_next = ST_FIN;
                end else if (item_reg.mode == MODE_LOAD) begin
                    state_next = ST_LOAD;
                end else if (item_reg.mode == MODE_STORE) begin
                    state_next = ST_STORE;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LOAD:  state_next = ST_FIN;
            ST_STORE: if (store_done) state_next = ST_FIN;
            ST_FIN: begin
                if (fin_fire) begin
                    state_next = (cls_reg == CLS_CLEARED) ? ST_SWEEP : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            segcnt_reg    <= SEGCNT_W'(4096);
            shift_reg     <= SHIFT_W'(7);
            gdx_reg       <= GDIM_W'(1);
            gdy_reg       <= GDIM_W'(1);
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP) begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + SEG_AW'(1);
            end else if (fin_fire) begin
                sweep_cnt_reg <= '0;
            end
            if (fin_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS:  base_reg   <= cfg_data;
                    CFG_SEGMENT_COUNT: segcnt_reg <= cfg_data[SEGCNT_W-1:0];
                    CFG_SEGMENT_SHIFT: shift_reg  <= cfg_data[SHIFT_W-1:0];
                    CFG_GRID_DIM_X:    gdx_reg    <= cfg_data[GDIM_W-1:0];
                    CFG_GRID_DIM_Y:    gdy_reg    <= cfg_data[GDIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Item datapath
    always_ff @(posedge aclk) begin
        // accept: offset and first partial products
        if (s_fire) begin
            item_reg   <= s_data;
            off_reg    <= s_data.address - base_reg;
            prod_y_reg <= 21'(s_data.block_y) * 21'(gdx_reg);
            gxy_reg    <= 22'(gdx_reg) * 22'(gdy_reg);
        end
        // segment number and range check, z partial product
        if (state_reg == ST_CALC) begin
            seg_idx_reg  <= seg_full[SEG_AW-1:0];
            in_range_reg <= (seg_full < ADDR_W'(seg_limit));
            prod_z_reg   <= 28'(item_reg.block_z) * 28'(gxy_reg);
        end
        // flat id and classification
        if (state_reg == ST_DISP) begin
            flat_reg <= flat_sum[ID_W-1:0];
            p_reg    <= off_reg;
            left_reg <= size_clamped;
            if (item_reg.mode == MODE_CLEAR) begin
                cls_reg <= CLS_CLEARED;
            end else if (!item_reg.is_global) begin
                cls_reg <= CLS_IGNORED;
            end else if (!in_range_reg) begin
                cls_reg <= CLS_OOR;
            end else begin
                case (item_reg.mode)
                    MODE_LOAD:  cls_reg <= CLS_LOAD;
                    MODE_STORE: cls_reg <= CLS_STORE;
                    default:    cls_reg <= CLS_OTHER;
                endcase
            end
        end
        if (state_reg == ST_LOAD && cross_hit) begin
            cls_reg <= CLS_CROSS;
        end
        // step to the first byte of the next segment
        if (state_reg == ST_STORE && !store_done) begin
            p_reg    <= p_reg + ADDR_W'(seg_rem);
            left_reg <= left_reg - seg_rem[SIZE_W-1:0];
        end
        if (fin_fire) begin
            out_data_reg.access_class       <= cls_reg;
            out_data_reg.flat_block_id      <=
                (cls_reg == CLS_IGNORED || cls_reg == CLS_CLEARED) ? '0 : flat_reg;
            out_data_reg.store_count        <= stats_post.stores;
            out_data_reg.load_count         <= stats_post.loads;
            out_data_reg.cross_load_count   <= stats_post.cross_loads;
            out_data_reg.out_of_range_count <= stats_post.out_of_range;
            out_data_reg.observed_min       <= stats_post.lowest;
            out_data_reg.observed_max       <= stats_post.highest;
        end
    end

endmodule

// ===== rtl/core/cbsot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsot_checker
// Port-level checks on the result channel of the tracker.
// ----------------------------------------------------------------------------
module cbsot_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  cbsot_pkg::out_word_t  m_data
);
    import cbsot_pkg::*;

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a clear leaves all statistics at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.access_class == CLS_CLEARED |->
            m_data.store_count == '0 && m_data.load_count == '0 &&
            m_data.cross_load_count == '0 && m_data.out_of_range_count == '0 &&
            m_data.observed_min == '0 && m_data.observed_max == '0 &&
            m_data.flat_block_id == '0)
        else $error("clear result carries stale statistics");

    // ignored accesses carry no block id
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.access_class == CLS_IGNORED |-> m_data.flat_block_id == '0)
        else $error("ignored access with nonzero block id");

    // cross-block loads are a subset of loads
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cross_load_count <= m_data.load_count)
        else $error("cross-load count exceeds load count");

    // min and max are set together and ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.observed_min != '0 |->
            m_data.observed_max != '0 && m_data.observed_min <= m_data.observed_max)
        else $error("observed address range inconsistent");

endmodule

bind cross_block_segment_overlap_tracker_top cbsot_checker u_cbsot_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== test/cbsot_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsot_monitor
// Watches the configuration, access and result channels of the segment
// overlap tracker. Keeps its own copy of the owner table, the counters and the
// observed address range, predicts one result word per accepted access word
// and compares every field of each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module cbsot_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cbsot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  cbsot_pkg::in_word_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  cbsot_pkg::out_word_t            m_data,
    output int                              mismatches,
    output int                              pending
);
    import cbsot_pkg::*;

    localparam int N_FIELDS   = 8;
    localparam int MAX_REPORT = 10;

    // Configuration copy
    logic [ADDR_W-1:0]   base_addr;
    logic [SEGCNT_W-1:0] seg_count;
    logic [SHIFT_W-1:0]  seg_shift;
    logic [GDIM_W-1:0]   dim_x;
    logic [GDIM_W-1:0]   dim_y;

    // Tracking state copy
    logic [ID_W-1:0]     owner_id  [SEGMENTS];
    logic                owner_vld [SEGMENTS];
    logic [CNT_W-1:0]    n_stores;
    logic [CNT_W-1:0]    n_loads;
    logic [CNT_W-1:0]    n_cross;
    logic [CNT_W-1:0]    n_oor;
    logic [ADDR_W-1:0]   addr_lo;
    logic [ADDR_W-1:0]   addr_hi;

    out_word_t           awaited_results [$];
    out_word_t           predicted;
    out_word_t           due_word;
    int                  words_seen;
    int                  reported;

    string field_name [N_FIELDS] = '{"access_class", "flat_block_id", "store_count",
        "load_count", "cross_load_count", "out_of_range_count", "observed_min",
        "observed_max"};

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [63:0] segment_of(input logic [63:0] a);
        return (a - base_addr) >> seg_shift;
    endfunction

    // Clear command and reset: no owners, counters and range back to zero
    function automatic void forget_all();
        foreach (owner_vld[i]) owner_vld[i] = 1'b0;
        n_stores = '0;
        n_loads  = '0;
        n_cross  = '0;
        n_oor    = '0;
        addr_lo  = '0;
        addr_hi  = '0;
    endfunction

    // Classify one access word and update the tracking state
    function automatic out_word_t track_access(input in_word_t w);
        out_word_t       r;
        logic [63:0]     lim;
        logic [63:0]     seg;
        logic [63:0]     s;
        logic [63:0]     flat64;
        logic [ID_W-1:0] flat;
        int              nbytes;
        r = '0;
        if (w.mode == MODE_CLEAR) begin
            forget_all();
            r.access_class = CLS_CLEARED;
        end else if (w.is_global) begin
            lim    = (seg_count > SEGMENTS) ? 64'(SEGMENTS) : 64'(seg_count);
            seg    = segment_of(w.address);
            flat64 = 64'(w.block_x) + 64'(w.block_y) * 64'(dim_x)
                   + 64'(w.block_z) * 64'(dim_x) * 64'(dim_y);
            flat   = flat64[ID_W-1:0];
            r.flat_block_id = flat;
            // zero stands for "unset", so it never sticks as a bound
            if (addr_lo == '0 || w.address < addr_lo) addr_lo = w.address;
            if (addr_hi == '0 || w.address > addr_hi) addr_hi = w.address;
            if (seg >= lim) begin
                n_oor = sat_inc(n_oor);
                r.access_class = CLS_OOR;
            end else if (w.mode == MODE_STORE) begin
                nbytes = (w.access_size > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES
                                                            : int'(w.access_size);
                // claim every segment touched; bytes past the table are dropped
                for (int n = 0; n < nbytes; n++) begin
                    s = segment_of(w.address + 64'(n));
                    if (s < lim) begin
                        owner_id[s[SEG_AW-1:0]]  = flat;
                        owner_vld[s[SEG_AW-1:0]] = 1'b1;
                    end
                end
                n_stores = sat_inc(n_stores);
                r.access_class = CLS_STORE;
            end else if (w.mode == MODE_LOAD) begin
                r.access_class = CLS_LOAD;
                if (owner_vld[seg[SEG_AW-1:0]] && owner_id[seg[SEG_AW-1:0]] != flat) begin
                    n_cross = sat_inc(n_cross);
                    r.access_class = CLS_CROSS;
                end
                n_loads = sat_inc(n_loads);
            end else begin
                r.access_class = CLS_OTHER;
            end
        end
        r.store_count        = n_stores;
        r.load_count         = n_loads;
        r.cross_load_count   = n_cross;
        r.out_of_range_count = n_oor;
        r.observed_min       = addr_lo;
        r.observed_max       = addr_hi;
        return r;
    endfunction

    function automatic logic [63:0] field_of(input out_word_t w, input int k);
        case (k)
            0:       return 64'(w.access_class);
            1:       return 64'(w.flat_block_id);
            2:       return 64'(w.store_count);
            3:       return 64'(w.load_count);
            4:       return 64'(w.cross_load_count);
            5:       return 64'(w.out_of_range_count);
            6:       return w.observed_min;
            default: return w.observed_max;
        endcase
    endfunction

    // Channel watch: configuration first, then access, then result
    always @(posedge aclk) begin
        if (!aresetn) begin
            base_addr = '0;
            seg_count = SEGCNT_W'(SEGMENTS);
            seg_shift = SHIFT_W'(7);
            dim_x     = GDIM_W'(1);
            dim_y     = GDIM_W'(1);
            forget_all();
            awaited_results.delete();
            words_seen = 0;
            reported   = 0;
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS:  base_addr = cfg_data;
                    CFG_SEGMENT_COUNT: seg_count = cfg_data[SEGCNT_W-1:0];
                    CFG_SEGMENT_SHIFT: seg_shift = cfg_data[SHIFT_W-1:0];
                    CFG_GRID_DIM_X:    dim_x     = cfg_data[GDIM_W-1:0];
                    CFG_GRID_DIM_Y:    dim_y     = cfg_data[GDIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = track_access(s_data);
                awaited_results.insert(awaited_results.size(), predicted);
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (reported < MAX_REPORT) begin
                        reported++;
                        $display("result word %0d arrived with nothing outstanding: %h",
                                 words_seen, m_data);
                    end
                end else begin
                    due_word = awaited_results.pop_front();
                    for (int k = 0; k < N_FIELDS; k++) begin
                        if (field_of(m_data, k) !== field_of(due_word, k)) begin
                            mismatches++;
                            if (reported < MAX_REPORT) begin
                                reported++;
                                $display("result word %0d %s: expected %0h, got %0h",
                                         words_seen, field_name[k],
                                         field_of(due_word, k), field_of(m_data, k));
                            end
                        end
                    end
                end
                words_seen++;
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives access and configuration words into the segment overlap tracker:
// a directed run over the special cases, then several configuration phases of
// random accesses aimed at a few hot segments and a small pool of blocks, with
// random stalls on both sides. The monitor checks every result word.
// ----------------------------------------------------------------------------
module testbench;
    import cbsot_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_ITEMS    = 40;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_word_t            m_data;
    int                   mismatches;
    int                   pending;
    logic                 rx_hold_req;

    // Shape of the current phase, used to aim random addresses
    logic [63:0]          gen_base;
    int                   gen_lim;
    int                   gen_shift;
    int                   hot_seg;
    logic [9:0]           pool_x [4];
    logic [9:0]           pool_y [4];
    logic [5:0]           pool_z [4];

    cross_block_segment_overlap_tracker_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    cbsot_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic in_word_t make_word(input logic [1:0] mode, input logic glob,
                                           input logic [9:0] bx, input logic [9:0] by,
                                           input logic [5:0] bz, input logic [63:0] addr,
                                           input logic [SIZE_W-1:0] size);
        in_word_t w;
        w.mode        = mode;
        w.is_global   = glob;
        w.block_x     = bx;
        w.block_y     = by;
        w.block_z     = bz;
        w.address     = addr;
        w.access_size = size;
        return w;
    endfunction

    // Random access word: mostly global loads and stores around hot segments
    function automatic in_word_t rand_access();
        in_word_t    w;
        int          r;
        int          p;
        logic [63:0] seg;
        logic [63:0] mask;
        logic [63:0] low;
        r = $urandom_range(0, 99);
        w.mode      = (r == 0) ? MODE_CLEAR :
                      (r <= 40) ? MODE_LOAD :
                      (r <= 75) ? MODE_STORE :
                      (r <= 89) ? MODE_OTHER : 2'($urandom_range(0, 2));
        w.is_global = (r == 0) ? 1'($urandom) : (r < 90);
        if ($urandom_range(0, 4) != 0) begin
            p = $urandom_range(0, 3);
            w.block_x = pool_x[p];
            w.block_y = pool_y[p];
            w.block_z = pool_z[p];
        end else begin
            w.block_x = 10'($urandom);
            w.block_y = 10'($urandom);
            w.block_z = 6'($urandom);
        end
        mask = (64'd1 << gen_shift) - 64'd1;
        low  = rand64() & mask;
        // sometimes sit near the segment end so stores straddle a boundary
        if ($urandom_range(0, 3) == 0) low = (mask - 64'($urandom_range(0, 15))) & mask;
        r = $urandom_range(0, 9);
        if (r < 4) seg = 64'($urandom_range(0, gen_lim + gen_lim / 8 + 1));
        else       seg = 64'(hot_seg + $urandom_range(0, 7));
        w.address = (r == 0) ? rand64() : gen_base + (seg << gen_shift) + low;
        r = $urandom_range(0, 9);
        w.access_size = (r == 0) ? '0 :
                        (r == 1) ? SIZE_W'($urandom_range(17, 31)) :
                                   SIZE_W'($urandom_range(1, 16));
        return w;
    endfunction

    // Offer one access word after a gap and wait for it to be taken
    task automatic send_word(input in_word_t w, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every outstanding result, let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One configuration setting followed by random traffic
    task automatic run_phase(input logic [63:0] base, input int count, input int shift,
                             input int gx, input int gy, input int n_items,
                             input bit hold_rx, input bit pause_mid);
        settle();
        // junk above each register's width must be dropped by the block
        cfg_write(CFG_BASE_ADDRESS, base);
        cfg_write(CFG_SEGMENT_COUNT, (rand64() << SEGCNT_W) | 64'(count));
        cfg_write(CFG_SEGMENT_SHIFT, (rand64() << SHIFT_W) | 64'(shift));
        cfg_write(CFG_GRID_DIM_X, (rand64() << GDIM_W) | 64'(gx));
        cfg_write(CFG_GRID_DIM_Y, (rand64() << GDIM_W) | 64'(gy));
        cfg_write(CFG_UNUSED_LO, rand64());
        cfg_write(CFG_UNUSED_HI, rand64());
        gen_base  = base;
        gen_lim   = (count > SEGMENTS) ? SEGMENTS : count;
        gen_shift = shift;
        hot_seg   = (gen_lim > 8) ? $urandom_range(0, gen_lim - 8) : 0;
        foreach (pool_x[i]) begin
            pool_x[i] = 10'($urandom);
            pool_y[i] = 10'($urandom);
            pool_z[i] = 6'($urandom);
        end
        if (hold_rx) rx_hold_req = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2) settle();
            send_word(rand_access(), (i < CALM_ITEMS) ? 0 : pick_gap());
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request
    initial begin : result_sink
        int gap_left;
        int calm_left;
        int hold_left;
        int r;
        m_ready   = 1'b0;
        gap_left  = 0;
        calm_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                m_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)       calm_left = $urandom_range(50, 200);
                else if (r < 18) gap_left  = $urandom_range(1, 3);
                else if (r < 20) gap_left  = $urandom_range(10, 40);
                m_ready <= (gap_left == 0);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rx_hold_req = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset setting: 128-byte segments, flat id x+y+z
        send_word(make_word(MODE_LOAD, 1'b1, 10'd0, 10'd0, 6'd0, 64'h0, 5'd1), pick_gap());
        send_word(make_word(MODE_STORE, 1'b1, 10'd1, 10'd0, 6'd0, 64'h100, 5'd16), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd2, 10'd0, 6'd0, 64'h100, 5'd1), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd1, 10'd0, 6'd0, 64'h10F, 5'd4), pick_gap());
        // zero-byte store counts but claims nothing
        send_word(make_word(MODE_STORE, 1'b1, 10'd5, 10'd0, 6'd0, 64'h200, 5'd0), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd6, 10'd0, 6'd0, 64'h200, 5'd1), pick_gap());
        // oversized store clamped, straddles two segments
        send_word(make_word(MODE_STORE, 1'b1, 10'd3, 10'd0, 6'd0, 64'h27C, 5'd31), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd4, 10'd0, 6'd0, 64'h280, 5'd1), pick_gap());
        send_word(make_word(MODE_OTHER, 1'b1, 10'd0, 10'd0, 6'd0, 64'h300, 5'd1), pick_gap());
        // first address past the table
        send_word(make_word(MODE_OTHER, 1'b1, 10'd0, 10'd0, 6'd0, 64'h80000, 5'd1), pick_gap());
        send_word(make_word(MODE_STORE, 1'b1, 10'd1, 10'd0, 6'd0, 64'h80000, 5'd8), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'h3FF, 10'h3FF, 6'h3F, '1, 5'h1F), pick_gap());
        // non-global words change nothing
        send_word(make_word(MODE_LOAD, 1'b0, 10'd2, 10'd0, 6'd0, 64'h100, 5'd1), pick_gap());
        send_word(make_word(MODE_STORE, 1'b0, 10'd2, 10'd0, 6'd0, 64'h100, 5'd16), pick_gap());
        send_word(make_word(MODE_OTHER, 1'b0, 10'd9, 10'd3, 6'd1, '1, 5'd3), pick_gap());
        // store running off the last segment
        send_word(make_word(MODE_STORE, 1'b1, 10'd7, 10'd0, 6'd0, 64'h7FFF8, 5'd16), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd8, 10'd0, 6'd0, 64'h7FFFC, 5'd1), pick_gap());
        send_word(make_word(MODE_STORE, 1'b1, 10'h3FF, 10'h3FF, 6'h3F, 64'h7FF00, 5'd16),
                  pick_gap());
        // clear, whether global or not
        send_word(make_word(MODE_CLEAR, 1'b0, 10'd0, 10'd0, 6'd0, 64'h0, 5'd0), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd2, 10'd0, 6'd0, 64'h100, 5'd1), pick_gap());
        send_word(make_word(MODE_CLEAR, 1'b1, 10'd4, 10'd5, 6'd6, '1, 5'd16), pick_gap());
        send_word(make_word(MODE_STORE, 1'b1, 10'd9, 10'd0, 6'd0, 64'h0, 5'd1), pick_gap());
        send_word(make_word(MODE_LOAD, 1'b1, 10'd8, 10'd0, 6'd0, 64'h40, 5'd1), pick_gap());

        // Random phases; extremes of every register among them
        run_phase(64'h1000, 16, 4, 4, 4, 250, 1'b0, 1'b0);
        run_phase(64'h0, SEGMENTS, 0, 1024, 1024, 250, 1'b1, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_F000, 8191, 16, 2047, 2047, 250, 1'b0, 1'b0);
        run_phase(rand64(), 0, 31, 1, 1, 80, 1'b0, 1'b0);
        run_phase(rand64(), 100, 7, 33, 7, 250, 1'b0, 1'b1);
        run_phase(64'h0, SEGMENTS, 7, 1, 1, 150, 1'b0, 1'b0);

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
